// ===== hdl/iop_pkg.sv =====
// Shared types and codes for the instruction operand patcher.
// Used by every module of the block; depends on nothing.
`default_nettype none

package iop_pkg;

   localparam int MAX_INSN_BYTES_DEF = 8;
   localparam int QUEUE_DEPTH_DEF    = 4;
   localparam int SLOTS              = 5;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_WARN      = 2'd1;
   localparam logic [1:0] STATUS_NOT_ALLOW = 2'd2;
   localparam logic [1:0] STATUS_JUMP_FAR  = 2'd3;

   localparam logic [3:0] SET_ANY     = 4'd0;
   localparam logic [3:0] SET_ZERO    = 4'd1;
   localparam logic [3:0] SET_0_2     = 4'd2;
   localparam logic [3:0] SET_0_3     = 4'd3;
   localparam logic [3:0] SET_0_7     = 4'd4;
   localparam logic [3:0] SET_RST_A   = 4'd5;
   localparam logic [3:0] SET_B       = 4'd6;
   localparam logic [3:0] SET_124     = 4'd7;
   localparam logic [3:0] SET_1248    = 4'd8;
   localparam logic [3:0] SET_HEX40   = 4'd9;
   localparam logic [3:0] SET_EIGHT   = 4'd10;

   localparam logic [2:0] FORMULA_SCALE        = 3'd1;
   localparam logic [2:0] FORMULA_ADD_SCALED   = 3'd2;
   localparam logic [2:0] FORMULA_SELECT_ADD   = 3'd3;
   localparam logic [2:0] FORMULA_SELECT_TWO   = 3'd4;
   localparam logic [2:0] FORMULA_SELECT_THREE = 3'd5;

   localparam logic [2:0] PATCH_UNSIGNED_LE = 3'd1;
   localparam logic [2:0] PATCH_SIGNED_LE   = 3'd2;
   localparam logic [2:0] PATCH_HIGH_BYTE   = 3'd3;
   localparam logic [2:0] PATCH_BIG_ENDIAN  = 3'd4;
   localparam logic [2:0] PATCH_PC_RELATIVE = 3'd5;

   typedef struct packed {
      logic        value_is_target;
      logic [31:0] value_or_target;
      logic [31:0] insn_address;
      logic [3:0]  insn_length;
      logic [3:0]  range_check;
      logic [2:0]  formula_kind;
      logic [2:0]  patch_kind;
      logic [2:0]  field_offset;
      logic [2:0]  field_size;
      logic [55:0] coef_bytes;
   } iop_req_type;

   typedef struct packed {
      logic       write_enable;
      logic [2:0] byte_position;
      logic [7:0] byte_value;
      logic [1:0] status;
      logic       last;
   } iop_rsp_type;

   typedef struct packed {
      logic [SLOTS-1:0]      valid;
      logic [SLOTS-1:0][2:0] pos;
      logic [SLOTS-1:0][7:0] data;
      logic [1:0]            status;
   } iop_entry_type;

endpackage

`default_nettype wire

// ===== hdl/instruction_operand_patcher.sv =====
// Top level of the instruction operand patcher.
// Depends on iop_pkg, iop_front, iop_queue and iop_back.
`default_nettype none

// One request per operand fixup; each request yields one result per byte it writes,
// at least one result and at most five. The front end takes a request every cycle
// while the queue has room, forms the operand before its input register and checks it after it; the back
// end emits one result per cycle while the result output is not stalled, so that
// write sequencer sets the sustained rate. A request with no write yields a single
// non-write result marked last. A request passes the front-end register, the queue,
// the current-request register and the result register. No clearing pass.
module instruction_operand_patcher import iop_pkg::*; #(
   parameter int MAX_INSN_BYTES = MAX_INSN_BYTES_DEF,
   parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire iop_req_type req_data,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output iop_rsp_type      rsp_data
);

   logic          q_push, q_full, q_pop, q_empty;
   iop_entry_type q_in, q_head;

   iop_front #(
      .MAX_INSN_BYTES(MAX_INSN_BYTES)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_data   (q_in)
   );

   iop_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head      (q_head)
   );

   iop_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_data.write_enable |-> rsp_data.last)
      else $error("non-write result not marked last");

   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_data.status == STATUS_NOT_ALLOW |-> !rsp_data.write_enable)
      else $error("write issued for a rejected value");

   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_pop && !rsp_data.last |=> !rsp_empty)
      else $error("gap inside the results of one request");

   assert property (@(posedge clock) disable iff (reset)
      req_full |-> q_full)
      else $error("front end blocked while queue has room");

endmodule

`default_nettype wire

// ===== hdl/iop_front.sv =====
// Front end: forms the operand value, checks its allowed set and lays out the byte writes.
// Depends on iop_pkg; feeds iop_queue.
`default_nettype none

module iop_front import iop_pkg::*; #(
   parameter int MAX_INSN_BYTES = MAX_INSN_BYTES_DEF
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_push,
   output logic               req_full,
   input  wire iop_req_type   req_data,
   input  wire logic          q_full,
   output logic               q_push,
   output iop_entry_type      q_data
);

   localparam int LEN_W = $clog2(MAX_INSN_BYTES + 1);

   iop_req_type        item_ff, item_in;
   logic [31:0]        uv_ff, uv_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic               valid_ff, valid_in;
   logic               accept;

   logic [LEN_W-1:0]   len_sat;
   logic signed [31:0] v;
   logic [7:0]         c [7];
   logic               allowed;
   logic [7:0]         formula_byte;
   logic               formula_on;
   logic [2:0]         sz;
   logic               is_be;
   logic               field_on;
   logic [1:0]         status;
   logic [3:0]         pos4;
   iop_entry_type      entry;

   assign req_full = valid_ff && q_full;
   assign accept   = req_push && !req_full;
   assign q_push   = valid_ff && !q_full;
   assign q_data   = entry;

   always_comb begin
      if (32'(req_data.insn_length) > 32'(MAX_INSN_BYTES)) begin
         len_sat = LEN_W'(MAX_INSN_BYTES);
      end else begin
         len_sat = LEN_W'(req_data.insn_length);
      end
      item_in  = accept ? req_data : item_ff;
      len_in   = accept ? len_sat : len_ff;
      uv_in    = uv_ff;
      if (accept) begin
         if (req_data.value_is_target) begin
            uv_in = req_data.value_or_target - (req_data.insn_address + 32'(len_sat));
         end else begin
            uv_in = req_data.value_or_target;
         end
      end
      valid_in = accept || (valid_ff && q_full);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
      uv_ff   <= uv_in;
      len_ff  <= len_in;
   end

   always_comb begin
      v = $signed(uv_ff);
      for (int k = 0; k < 7; k++) begin
         c[k] = item_ff.coef_bytes[8*k +: 8];
      end

      unique case (item_ff.range_check)
         SET_ANY:   allowed = 1'b1;
         SET_ZERO:  allowed = (uv_ff == 32'd0);
         SET_0_2:   allowed = (uv_ff <= 32'd2);
         SET_0_3:   allowed = (uv_ff <= 32'd3);
         SET_0_7:   allowed = (uv_ff <= 32'd7);
         SET_RST_A: allowed = (uv_ff <= 32'd8) || uv_ff == 32'h10 || uv_ff == 32'h18
                              || uv_ff == 32'h20 || uv_ff == 32'h28 || uv_ff == 32'h30
                              || uv_ff == 32'h38;
         SET_B:     allowed = (uv_ff >= 32'd2 && uv_ff <= 32'd5) || uv_ff == 32'd7
                              || uv_ff == 32'h10 || uv_ff == 32'h18 || uv_ff == 32'h20
                              || uv_ff == 32'h28 || uv_ff == 32'h38;
         SET_124:   allowed = uv_ff == 32'd1 || uv_ff == 32'd2 || uv_ff == 32'd4;
         SET_1248:  allowed = uv_ff == 32'd1 || uv_ff == 32'd2 || uv_ff == 32'd4
                              || uv_ff == 32'd8;
         SET_HEX40: allowed = (uv_ff == 32'h40);
         SET_EIGHT: allowed = (uv_ff == 32'd8);
         default:   allowed = 1'b0;
      endcase

      formula_on = 1'b1;
      unique case (item_ff.formula_kind)
         FORMULA_SCALE:
            formula_byte = c[0] + ((v < 32'sd8) ? {uv_ff[4:0], 3'b000} : uv_ff[7:0]);
         FORMULA_ADD_SCALED:
            formula_byte = c[0] + 8'(c[1] * uv_ff[7:0]);
         FORMULA_SELECT_ADD:
            formula_byte = (uv_ff == 32'(c[0])) ? c[1] : c[2] + uv_ff[7:0];
         FORMULA_SELECT_TWO:
            formula_byte = (uv_ff == 32'(c[0])) ? c[1] :
                           (uv_ff == 32'(c[2])) ? c[3] : c[4];
         FORMULA_SELECT_THREE:
            formula_byte = (uv_ff == 32'(c[0])) ? c[1] :
                           (uv_ff == 32'(c[2])) ? c[3] :
                           (uv_ff == 32'(c[4])) ? c[5] : c[6];
         default: begin
            formula_byte = 8'd0;
            formula_on   = 1'b0;
         end
      endcase

      status   = STATUS_OK;
      field_on = 1'b1;
      is_be    = 1'b0;
      sz       = (item_ff.field_size > 3'd4) ? 3'd4 : item_ff.field_size;
      unique case (item_ff.patch_kind)
         PATCH_UNSIGNED_LE, PATCH_BIG_ENDIAN: begin
            is_be = (item_ff.patch_kind == PATCH_BIG_ENDIAN);
            if ((sz == 3'd1 && (v < -32'sd128 || v > 32'sd255)) ||
                (sz == 3'd2 && (v < -32'sd32768 || v > 32'sd65535))) begin
               status = STATUS_WARN;
            end
         end
         PATCH_SIGNED_LE: begin
            if ((sz == 3'd1 && (v < -32'sd128 || v > 32'sd127)) ||
                (sz == 3'd2 && (v < -32'sd32768 || v > 32'sd32767))) begin
               status = STATUS_WARN;
            end
         end
         PATCH_HIGH_BYTE: begin
            sz = 3'd1;
            if (uv_ff[15:8] != 8'h00 && uv_ff[15:8] != 8'hFF) begin
               status = STATUS_WARN;
            end
         end
         PATCH_PC_RELATIVE: begin
            sz = (item_ff.field_size > 3'd2) ? 3'd2 : item_ff.field_size;
            if ((sz == 3'd1 && (v < -32'sd128 || v > 32'sd127)) ||
                (sz == 3'd2 && (v < -32'sd32768 || v > 32'sd32767))) begin
               status = STATUS_JUMP_FAR;
            end
         end
         default: begin
            field_on = 1'b0;
            sz       = 3'd0;
         end
      endcase

      entry.valid[0] = allowed && formula_on
                       && (32'(item_ff.field_offset) < 32'(len_ff));
      entry.pos[0]   = item_ff.field_offset;
      entry.data[0]  = formula_byte;
      for (int i = 0; i < 4; i++) begin
         if (is_be) begin
            pos4 = 4'(item_ff.field_offset) + 4'(sz) - 4'd1 - 4'(i);
         end else begin
            pos4 = 4'(item_ff.field_offset) + 4'(i);
         end
         entry.valid[i+1] = allowed && field_on && (3'(i) < sz) && !pos4[3]
                            && (32'(pos4) < 32'(len_ff));
         entry.pos[i+1]   = pos4[2:0];
         entry.data[i+1]  = uv_ff[8*i +: 8];
      end
      entry.status = allowed ? status : STATUS_NOT_ALLOW;
   end

endmodule

`default_nettype wire

// ===== hdl/iop_queue.sv =====
// Short request queue between the front end and the write sequencer.
// Depends on iop_pkg for the entry type.
`default_nettype none

module iop_queue import iop_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire iop_entry_type push_data,
   output logic               full,
   input  wire logic          pop,
   output logic               empty,
   output iop_entry_type      head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   iop_entry_type      store_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = store_ff[rd_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
      if (do_push) begin
         store_ff[wr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/iop_back.sv =====
// Back end: walks the byte writes of one request and emits them, one result per cycle while not stalled.
// Depends on iop_pkg; drains iop_queue into the result register.
`default_nettype none

module iop_back import iop_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          q_empty,
   input  wire iop_entry_type q_head,
   output logic               q_pop,
   output logic               rsp_empty,
   input  wire logic          rsp_pop,
   output iop_rsp_type        rsp_data
);

   iop_entry_type     cur_ff, cur_in;
   logic              cur_valid_ff, cur_valid_in;
   iop_rsp_type       out_ff, out_in;
   logic              out_valid_ff, out_valid_in;
   logic              out_free;
   logic              emit;
   logic [2:0]        sel;
   logic [SLOTS-1:0]  rest;
   iop_rsp_type       res;

   assign out_free  = !out_valid_ff || rsp_pop;
   assign emit      = cur_valid_ff && out_free;
   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      sel = 3'd0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (cur_ff.valid[i]) begin
            sel = 3'(i);
         end
      end
      rest = cur_ff.valid;
      rest[sel] = 1'b0;

      res.write_enable  = |cur_ff.valid;
      res.byte_position = res.write_enable ? cur_ff.pos[sel] : 3'd0;
      res.byte_value    = res.write_enable ? cur_ff.data[sel] : 8'd0;
      res.status        = cur_ff.status;
      res.last          = (rest == '0);

      q_pop        = !q_empty && (!cur_valid_ff || (emit && res.last));
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      if (q_pop) begin
         cur_in       = q_head;
         cur_valid_in = 1'b1;
      end else if (emit) begin
         cur_in.valid = rest;
         cur_valid_in = !res.last;
      end

      out_in       = emit ? res : out_ff;
      out_valid_in = emit || (out_valid_ff && !rsp_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         out_valid_ff <= out_valid_in;
      end
      cur_ff <= cur_in;
      out_ff <= out_in;
   end

endmodule

`default_nettype wire

// ===== verif/instruction_operand_patcher_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for instruction_operand_patcher: directed fixups, then random ones.
// Every popped result is compared with a listed or a predicted write. Depends on iop_pkg.
module instruction_operand_patcher_test;
   import iop_pkg::*;

   localparam logic [2:0] FORMULA_NONE    = 3'd0;
   localparam logic [2:0] FORMULA_UNKNOWN = 3'd6;
   localparam logic [2:0] PATCH_NONE      = 3'd0;
   localparam logic [2:0] PATCH_UNKNOWN   = 3'd7;
   localparam logic [3:0] SET_UNKNOWN     = 4'd11;
   localparam logic [3:0] SET_LAST_CODE   = 4'd15;

   localparam int RESET_CYCLES   = 7;
   localparam int RANDOM_ITEMS   = 400;
   localparam int CALM_ITEMS     = 50;
   localparam int HOLD_CYCLES    = 200;
   localparam int HOLD_AFTER     = 60;
   localparam int DRAIN_CYCLES   = 12;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct {
      iop_req_type req;
      bit          known;
      iop_rsp_type rsp;
   } stim_row_type;

   logic        clock;
   logic        reset     = 1'b1;
   logic        req_push  = 1'b0;
   logic        req_full;
   iop_req_type req_data  = '0;
   logic        rsp_empty;
   logic        rsp_pop   = 1'b0;
   iop_rsp_type rsp_data;

   iop_rsp_type  expected_writes[$];
   iop_rsp_type  staged_bytes[$];
   stim_row_type directed_rows[$];
   iop_rsp_type  want_rsp;
   int           mismatch_count = 0;
   int           writes_popped  = 0;
   int           stuck_cycles   = 0;
   bit           calm           = 1'b0;

   instruction_operand_patcher dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic bit set_admits(input int v, input logic [3:0] set_code);
      case (set_code)
         SET_ANY:   return 1'b1;
         SET_ZERO:  return v == 0;
         SET_0_2:   return v >= 0 && v <= 2;
         SET_0_3:   return v >= 0 && v <= 3;
         SET_0_7:   return v >= 0 && v <= 7;
         SET_RST_A: return (v >= 0 && v <= 8) || (v inside {16, 24, 32, 40, 48, 56});
         SET_B:     return (v >= 2 && v <= 5) || (v inside {7, 16, 24, 32, 40, 56});
         SET_124:   return v inside {1, 2, 4};
         SET_1248:  return v inside {1, 2, 4, 8};
         SET_HEX40: return v == 64;
         SET_EIGHT: return v == 8;
         default:   return 1'b0;
      endcase
   endfunction

   function automatic void stage_byte(input int pos, input int len, input logic [31:0] val);
      if (pos < len && pos < 8 && staged_bytes.size() < SLOTS)
         staged_bytes.insert(staged_bytes.size(),
                             '{1'b1, 3'(pos), val[7:0], STATUS_OK, 1'b0});
   endfunction

   function automatic void predict_patches(input iop_req_type rq);
      int          len;
      int          off;
      int          sz;
      int          v;
      logic [31:0] uv;
      logic [7:0]  cf[7];
      logic [1:0]  st;
      iop_rsp_type w;
      len = (int'(rq.insn_length) > MAX_INSN_BYTES_DEF) ? MAX_INSN_BYTES_DEF
                                                        : int'(rq.insn_length);
      off = int'(rq.field_offset);
      for (int k = 0; k < 7; k++)
         cf[k] = rq.coef_bytes[8*k +: 8];
      uv = rq.value_is_target ? rq.value_or_target - rq.insn_address - 32'(len)
                              : rq.value_or_target;
      v = signed'(uv);
      st = STATUS_OK;
      staged_bytes.delete();
      if (!set_admits(v, rq.range_check)) begin
         st = STATUS_NOT_ALLOW;
      end else begin
         case (rq.formula_kind)
            FORMULA_SCALE:
               stage_byte(off, len, {24'd0, cf[0]} + ((v < 8) ? uv * 32'd8 : uv));
            FORMULA_ADD_SCALED:
               stage_byte(off, len, {24'd0, cf[0]} + {24'd0, cf[1]} * uv);
            FORMULA_SELECT_ADD:
               stage_byte(off, len, (uv == {24'd0, cf[0]}) ? {24'd0, cf[1]}
                                                           : {24'd0, cf[2]} + uv);
            FORMULA_SELECT_TWO:
               stage_byte(off, len, {24'd0, (uv == {24'd0, cf[0]}) ? cf[1] :
                                            (uv == {24'd0, cf[2]}) ? cf[3] : cf[4]});
            FORMULA_SELECT_THREE:
               stage_byte(off, len, {24'd0, (uv == {24'd0, cf[0]}) ? cf[1] :
                                            (uv == {24'd0, cf[2]}) ? cf[3] :
                                            (uv == {24'd0, cf[4]}) ? cf[5] : cf[6]});
            default: ;
         endcase
         case (rq.patch_kind)
            PATCH_UNSIGNED_LE, PATCH_BIG_ENDIAN: begin
               sz = (rq.field_size > 3'd4) ? 4 : int'(rq.field_size);
               if ((sz == 1 && (v < -128 || v > 255)) || (sz == 2 && (v < -32768 || v > 65535)))
                  st = STATUS_WARN;
               for (int i = 0; i < sz; i++)
                  stage_byte((rq.patch_kind == PATCH_UNSIGNED_LE) ? off + i : off + sz - 1 - i,
                             len, uv >> (8 * i));
            end
            PATCH_SIGNED_LE: begin
               sz = (rq.field_size > 3'd4) ? 4 : int'(rq.field_size);
               if ((sz == 1 && (v < -128 || v > 127)) || (sz == 2 && (v < -32768 || v > 32767)))
                  st = STATUS_WARN;
               for (int i = 0; i < sz; i++)
                  stage_byte(off + i, len, uv >> (8 * i));
            end
            PATCH_HIGH_BYTE: begin
               if (uv[15:8] != 8'h00 && uv[15:8] != 8'hFF)
                  st = STATUS_WARN;
               stage_byte(off, len, uv);
            end
            PATCH_PC_RELATIVE: begin
               sz = (rq.field_size > 3'd2) ? 2 : int'(rq.field_size);
               if ((sz == 1 && (v < -128 || v > 127)) || (sz == 2 && (v < -32768 || v > 32767)))
                  st = STATUS_JUMP_FAR;
               for (int i = 0; i < sz; i++)
                  stage_byte(off + i, len, uv >> (8 * i));
            end
            default: ;
         endcase
      end
      if (staged_bytes.size() == 0)
         staged_bytes.insert(0, '{1'b0, 3'd0, 8'd0, STATUS_OK, 1'b0});
      while (staged_bytes.size() != 0) begin
         w = staged_bytes.pop_front();
         w.status = st;
         w.last = (staged_bytes.size() == 0);
         expected_writes.insert(expected_writes.size(), w);
      end
   endfunction

   function automatic iop_req_type mk_req(input bit tgt, input logic [31:0] val,
                                          input logic [31:0] addr, input logic [3:0] len,
                                          input logic [3:0] set_code, input logic [2:0] formula,
                                          input logic [2:0] patch, input logic [2:0] off,
                                          input logic [2:0] size, input logic [55:0] coef);
      return '{tgt, val, addr, len, set_code, formula, patch, off, size, coef};
   endfunction

   function automatic iop_rsp_type one_rsp(input bit we, input logic [2:0] pos,
                                           input logic [7:0] val, input logic [1:0] st);
      return '{we, pos, val, st, 1'b1};
   endfunction

   function automatic void add_row(input iop_req_type rq);
      directed_rows.insert(directed_rows.size(), '{rq, 1'b0, '0});
   endfunction

   function automatic void add_known(input iop_req_type rq, input iop_rsp_type rsp);
      directed_rows.insert(directed_rows.size(), '{rq, 1'b1, rsp});
   endfunction

   function automatic int pick_value(input logic [3:0] set_code);
      int b_members[10]    = '{2, 3, 4, 5, 7, 16, 24, 32, 40, 56};
      int bound_values[12] = '{-32769, -32768, -129, -128, 127, 128,
                               255, 256, 32767, 32768, 65535, 65536};
      int r;
      case ($urandom_range(0, 9))
         0: return int'($urandom);
         1: return int'($urandom_range(0, 600)) - 300;
         2: return bound_values[$urandom_range(0, 11)];
         default: ;
      endcase
      case (set_code)
         SET_ANY:   return int'($urandom_range(0, 511)) - 256;
         SET_ZERO:  return 0;
         SET_0_2:   return int'($urandom_range(0, 2));
         SET_0_3:   return int'($urandom_range(0, 3));
         SET_0_7:   return int'($urandom_range(0, 7));
         SET_RST_A: begin
            r = int'($urandom_range(0, 14));
            return (r <= 8) ? r : 16 + 8 * (r - 9);
         end
         SET_B:     return b_members[$urandom_range(0, 9)];
         SET_124:   return 1 << $urandom_range(0, 2);
         SET_1248:  return 1 << $urandom_range(0, 3);
         SET_HEX40: return 64;
         SET_EIGHT: return 8;
         default:   return int'($urandom_range(0, 300));
      endcase
   endfunction

   function automatic iop_req_type rand_req();
      iop_req_type rq;
      int          v;
      int          len;
      int          k;
      rq.range_check = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(11, 15))
                                                  : 4'($urandom_range(0, 10));
      v = pick_value(rq.range_check);
      case ($urandom_range(0, 9))
         0:       rq.insn_length = 4'($urandom_range(9, 15));
         1:       rq.insn_length = 4'd0;
         default: rq.insn_length = 4'($urandom_range(1, 8));
      endcase
      len = (int'(rq.insn_length) > MAX_INSN_BYTES_DEF) ? MAX_INSN_BYTES_DEF
                                                        : int'(rq.insn_length);
      rq.insn_address = $urandom;
      rq.value_is_target = 1'($urandom_range(0, 1));
      rq.value_or_target = rq.value_is_target ? 32'(v) + rq.insn_address + 32'(len) : 32'(v);
      rq.formula_kind = 3'($urandom_range(0, 7));
      rq.patch_kind = 3'($urandom_range(0, 7));
      rq.field_offset = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7))
                                                   : 3'($urandom_range(0, 2));
      rq.field_size = ($urandom_range(0, 5) == 0) ? 3'($urandom_range(0, 7))
                                                 : 3'($urandom_range(1, 4));
      rq.coef_bytes = 56'({$urandom, $urandom});
      k = int'($urandom_range(0, 3));
      if (v >= 0 && v <= 255 && k < 3)
         rq.coef_bytes[16*k +: 8] = 8'(v);
      return rq;
   endfunction

   task automatic offer(input stim_row_type row, input bit may_idle);
      int gap;
      if (may_idle && $urandom_range(0, 3) == 0) begin
         req_push <= 1'b0;
         gap = int'($urandom_range(1, 4));
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= row.req;
      do @(posedge clock); while (req_full);
      if (row.known)
         expected_writes.insert(expected_writes.size(), row.rsp);
      else
         predict_patches(row.req);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         writes_popped <= writes_popped + 1;
         if (expected_writes.size() == 0) begin
            $error("unexpected request result: %p", rsp_data);
            mismatch_count++;
         end else begin
            want_rsp = expected_writes.pop_front();
            if (rsp_data.write_enable !== want_rsp.write_enable) begin
               $error("write_enable: expected %0d, got %0d",
                      want_rsp.write_enable, rsp_data.write_enable);
               mismatch_count++;
            end
            if (rsp_data.byte_position !== want_rsp.byte_position) begin
               $error("byte_position: expected %0d, got %0d",
                      want_rsp.byte_position, rsp_data.byte_position);
               mismatch_count++;
            end
            if (rsp_data.byte_value !== want_rsp.byte_value) begin
               $error("byte_value: expected %02h, got %02h",
                      want_rsp.byte_value, rsp_data.byte_value);
               mismatch_count++;
            end
            if (rsp_data.status !== want_rsp.status) begin
               $error("status: expected %0d, got %0d", want_rsp.status, rsp_data.status);
               mismatch_count++;
            end
            if (rsp_data.last !== want_rsp.last) begin
               $error("last: expected %0d, got %0d", want_rsp.last, rsp_data.last);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty))
         stuck_cycles <= 0;
      else
         stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      int stall_left;
      int tick;
      bit held;
      stall_left = 0;
      tick = 0;
      held = 1'b0;
      wait (!reset);
      forever begin
         @(posedge clock);
         tick++;
         if (!held && writes_popped >= HOLD_AFTER) begin
            held = 1'b1;
            stall_left = HOLD_CYCLES;
         end else if (stall_left == 0 && !calm && tick[6] && $urandom_range(0, 4) == 0) begin
            stall_left = int'($urandom_range(1, 4));
         end
         if (stall_left > 0) begin
            rsp_pop <= 1'b0;
            stall_left--;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   initial begin
      stim_row_type row;
      add_known(mk_req(0, 0, 0, 8, SET_ANY, FORMULA_NONE, PATCH_NONE, 0, 1, 56'h0),
                one_rsp(0, 0, 8'h00, STATUS_OK));
      add_known(mk_req(0, 5, 0, 8, SET_ZERO, FORMULA_NONE, PATCH_UNSIGNED_LE, 0, 1, 56'h0),
                one_rsp(0, 0, 8'h00, STATUS_NOT_ALLOW));
      add_known(mk_req(0, 0, 0, 8, SET_UNKNOWN, FORMULA_SCALE, PATCH_UNSIGNED_LE, 0, 1, 56'h0),
                one_rsp(0, 0, 8'h00, STATUS_NOT_ALLOW));
      add_known(mk_req(1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 15, SET_LAST_CODE, FORMULA_SELECT_THREE,
                       PATCH_PC_RELATIVE, 7, 7, 56'hFF_FFFF_FFFF_FFFF),
                one_rsp(0, 0, 8'h00, STATUS_NOT_ALLOW));
      add_known(mk_req(0, 32'h1234, 0, 8, SET_ANY, FORMULA_NONE, PATCH_UNSIGNED_LE, 0, 1, 56'h0),
                one_rsp(1, 0, 8'h34, STATUS_WARN));
      add_known(mk_req(0, 32'hFFFF_FF80, 0, 8, SET_ANY, FORMULA_NONE, PATCH_SIGNED_LE, 3, 1,
                       56'h0),
                one_rsp(1, 3, 8'h80, STATUS_OK));
      add_known(mk_req(1, 32'h10CA, 32'h1000, 2, SET_ANY, FORMULA_NONE, PATCH_PC_RELATIVE, 1, 1,
                       56'h0),
                one_rsp(1, 1, 8'hC8, STATUS_JUMP_FAR));
      add_row(mk_req(1, 32'h2000, 32'h2000, 3, SET_ANY, FORMULA_NONE, PATCH_PC_RELATIVE, 1, 5,
                     56'h0));
      add_row(mk_req(0, 32'h7FFF_FFFF, 0, 8, SET_ANY, FORMULA_NONE, PATCH_UNSIGNED_LE, 0, 4,
                     56'h0));
      add_row(mk_req(0, 32'h8000_0000, 0, 8, SET_ANY, FORMULA_NONE, PATCH_SIGNED_LE, 4, 4, 56'h0));
      add_row(mk_req(0, 32'h1234, 0, 4, SET_ANY, FORMULA_NONE, PATCH_BIG_ENDIAN, 2, 2, 56'h0));
      add_known(mk_req(0, 32'h1234, 0, 2, SET_ANY, FORMULA_NONE, PATCH_HIGH_BYTE, 0, 1, 56'h0),
                one_rsp(1, 0, 8'h34, STATUS_WARN));
      add_known(mk_req(0, 32'hFFFF_FF80, 0, 2, SET_ANY, FORMULA_NONE, PATCH_HIGH_BYTE, 1, 3,
                       56'h0),
                one_rsp(1, 1, 8'h80, STATUS_OK));
      add_known(mk_req(0, 3, 0, 1, SET_0_7, FORMULA_SCALE, PATCH_NONE, 0, 1, 56'h40),
                one_rsp(1, 0, 8'h58, STATUS_OK));
      add_row(mk_req(0, 32'h38, 0, 1, SET_RST_A, FORMULA_SCALE, PATCH_NONE, 0, 1, 56'hC7));
      add_row(mk_req(0, 4, 0, 2, SET_124, FORMULA_ADD_SCALED, PATCH_SIGNED_LE, 1, 1, 56'h0310));
      add_row(mk_req(0, 2, 0, 8, SET_0_2, FORMULA_SELECT_ADD, PATCH_NONE, 5, 1, 56'h20_99_02));
      add_row(mk_req(0, 1, 0, 8, SET_0_3, FORMULA_SELECT_ADD, PATCH_NONE, 5, 1, 56'h20_99_02));
      add_row(mk_req(0, 8, 0, 8, SET_1248, FORMULA_SELECT_TWO, PATCH_NONE, 2, 1,
                     56'h33_22_08_11_01));
      add_row(mk_req(1, 32'h8000_0048, 32'h8000_0000, 8, SET_HEX40, FORMULA_SELECT_THREE,
                     PATCH_UNSIGNED_LE, 0, 4, 56'h66_55_40_04_03_02_01));
      add_row(mk_req(1, 32'h110, 32'h100, 15, SET_EIGHT, FORMULA_NONE, PATCH_PC_RELATIVE, 7, 1,
                     56'h0));
      add_known(mk_req(0, 9, 0, 8, SET_ANY, FORMULA_UNKNOWN, PATCH_UNKNOWN, 0, 1, 56'hFF),
                one_rsp(0, 0, 8'h00, STATUS_OK));
      add_row(mk_req(0, 32'hA1B2_C3D4, 0, 8, SET_ANY, FORMULA_NONE, PATCH_UNSIGNED_LE, 6, 4,
                     56'h0));
      add_known(mk_req(0, 7, 0, 8, SET_ANY, FORMULA_NONE, PATCH_UNSIGNED_LE, 0, 0, 56'h0),
                one_rsp(0, 0, 8'h00, STATUS_OK));
      add_known(mk_req(0, 5, 0, 0, SET_ANY, FORMULA_NONE, PATCH_UNSIGNED_LE, 0, 2, 56'h0),
                one_rsp(0, 0, 8'h00, STATUS_OK));
      add_row(mk_req(0, 32'hFFFF_8000, 32'hFFFF_FFFF, 8, SET_ANY, FORMULA_ADD_SCALED,
                     PATCH_SIGNED_LE, 0, 7, 56'hFF_FFFF_FFFF_FFFF));

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         offer(directed_rows[i], 1'($urandom_range(0, 1)));
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i >= RANDOM_ITEMS - CALM_ITEMS)
            calm = 1'b1;
         row.req = rand_req();
         row.known = 1'b0;
         row.rsp = '0;
         offer(row, !calm && ((i / 24) % 2 == 0));
      end
      req_push <= 1'b0;

      while (expected_writes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
